// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRP_ASSERT_SAME(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRP_ASSERT_NEXT(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/prp_pkg.sv =====
package prp_pkg;

	// Width of the yaw-rotated coordinates (x1, z1).
	localparam int ROT_W = 19;
	// Width of the pitch-rotated coordinates (y2, z2).
	localparam int PIT_W = 22;
	// Divisor width and quotient width of the perspective division.
	localparam int DIV_W = 20;
	localparam int QUO_W = DIV_W - 1;
	localparam int REM_W = DIV_W + 1;
	// The dividend is 2^NUM_SHIFT plus half the divisor.
	localparam int NUM_SHIFT = 26;

	// Rounding constants: half an LSB for each right shift.
	localparam int RND14 = 1 << 13;
	localparam int RND16 = 1 << 15;
	localparam int RND26 = 1 << 25;

	// 0.22 in Q0.16, one in Q.12, and the smallest allowed divisor (1/16).
	localparam logic signed [15:0] PERSP_K = 16'sd14418;
	localparam int DIV_ONE = 4096;
	localparam int DIV_MIN = 256;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// Configuration port.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam logic [2:0] REG_COS_YAW     = 3'd0;
	localparam logic [2:0] REG_SIN_YAW     = 3'd1;
	localparam logic [2:0] REG_COS_PITCH   = 3'd2;
	localparam logic [2:0] REG_SIN_PITCH   = 3'd3;
	localparam logic [2:0] REG_CENTRE_X    = 3'd4;
	localparam logic [2:0] REG_CENTRE_Y    = 3'd5;
	localparam logic [2:0] REG_PIXEL_SCALE = 3'd6;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
	} prp_in_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic signed [15:0] view_depth;
		logic [15:0]        persp_factor;
		logic               clipped;
	} prp_out_t;

	typedef struct packed {
		logic signed [15:0] cos_yaw;
		logic signed [15:0] sin_yaw;
		logic signed [15:0] cos_pitch;
		logic signed [15:0] sin_pitch;
		logic [15:0]        centre_x;
		logic [15:0]        centre_y;
		logic [15:0]        pixel_scale;
	} prp_cfg_t;

	// One rotated point with its clamped divisor, as handed from front to back.
	typedef struct packed {
		logic signed [ROT_W-1:0] x1;
		logic signed [PIT_W-1:0] y2;
		logic signed [PIT_W-1:0] z2;
		logic [DIV_W-1:0]        div;
		logic                    clip;
	} prp_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} prp_qstat_t;

	// Saturate to signed 16 bits; the top bit of the result flags saturation.
	function automatic logic [16:0] sat16(input logic signed [33:0] v);
		logic [16:0] r;
		if (v > 34'sd32767) begin
			r = {1'b1, 16'h7FFF};
		end else if (v < -34'sd32768) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, v[15:0]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/prp_front.sv =====
module prp_front import prp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  prp_cfg_t   cfg,
	input  logic       pt_valid,
	output logic       pt_ready,
	input  prp_in_t    pt,
	input  prp_qstat_t q_stat,
	output logic       push,
	output prp_job_t   job
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [31:0] xcy_s1, zsy_s1, zcy_s1, xsy_s1, ycp_s1, ysp_s1;
	logic signed [ROT_W-1:0] x1_s2, z1_s2;
	logic signed [31:0] ycp_s2, ysp_s2;
	logic signed [ROT_W-1:0] x1_s3;
	logic signed [31:0] ycp_s3, ysp_s3;
	logic signed [ROT_W+15:0] zsp_s3, zcp_s3;
	logic signed [ROT_W-1:0] x1_s4, x1_s5;
	logic signed [PIT_W-1:0] y2_s4, z2_s4, y2_s5, z2_s5;
	logic signed [PIT_W+15:0] kz_s5;
	prp_job_t job_s6;

	logic signed [ROT_W+14:0] x1_sum, z1_sum;
	logic signed [PIT_W+13:0] y2_sum, z2_sum;
	logic signed [PIT_W+16:0] kz_sum;
	logic signed [PIT_W:0] d_raw;
	logic d_low;

	// The whole front advances unless a finished point waits on a full queue.
	assign en       = !v_s6 || !q_stat.full;
	assign pt_ready = en;
	assign push     = en && v_s6;
	assign job      = job_s6;

	// Rounded sums of the yaw and pitch rotations, and the perspective divisor.
	always_comb begin
		x1_sum = (ROT_W+15)'(xcy_s1) + (ROT_W+15)'(zsy_s1) + (ROT_W+15)'(RND14);
		z1_sum = (ROT_W+15)'(zcy_s1) - (ROT_W+15)'(xsy_s1) + (ROT_W+15)'(RND14);
		y2_sum = (PIT_W+14)'(ycp_s3) - (PIT_W+14)'(zsp_s3) + (PIT_W+14)'(RND14);
		z2_sum = (PIT_W+14)'(ysp_s3) + (PIT_W+14)'(zcp_s3) + (PIT_W+14)'(RND14);
		kz_sum = (PIT_W+17)'(kz_s5) + (PIT_W+17)'(RND16);
		d_raw  = $signed(kz_sum[PIT_W+16:16]) + (PIT_W+1)'(DIV_ONE);
		d_low  = d_raw < (PIT_W+1)'(DIV_MIN);
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Datapath: products, yaw sums, pitch products, pitch sums, depth scaling, divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			xcy_s1 <= pt.point_x * cfg.cos_yaw;
			zsy_s1 <= pt.point_z * cfg.sin_yaw;
			zcy_s1 <= pt.point_z * cfg.cos_yaw;
			xsy_s1 <= pt.point_x * cfg.sin_yaw;
			ycp_s1 <= pt.point_y * cfg.cos_pitch;
			ysp_s1 <= pt.point_y * cfg.sin_pitch;

			x1_s2  <= x1_sum[ROT_W+13:14];
			z1_s2  <= z1_sum[ROT_W+13:14];
			ycp_s2 <= ycp_s1;
			ysp_s2 <= ysp_s1;

			x1_s3  <= x1_s2;
			ycp_s3 <= ycp_s2;
			ysp_s3 <= ysp_s2;
			zsp_s3 <= z1_s2 * cfg.sin_pitch;
			zcp_s3 <= z1_s2 * cfg.cos_pitch;

			x1_s4 <= x1_s3;
			y2_s4 <= y2_sum[PIT_W+13:14];
			z2_s4 <= z2_sum[PIT_W+13:14];

			x1_s5 <= x1_s4;
			y2_s5 <= y2_s4;
			z2_s5 <= z2_s4;
			kz_s5 <= z2_s4 * PERSP_K;

			job_s6.x1   <= x1_s5;
			job_s6.y2   <= y2_s5;
			job_s6.z2   <= z2_s5;
			job_s6.div  <= d_low ? DIV_W'(DIV_MIN) : DIV_W'(d_raw);
			job_s6.clip <= d_low;
		end
	end

endmodule

// ===== rtl/prp_queue.sv =====
module prp_queue import prp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  prp_job_t   wr_job,
	input  logic       pop,
	output prp_job_t   rd_job,
	output prp_qstat_t q_stat
);

	prp_job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign rd_job       = mem_q[rd_ptr_q];

	// Pointers and fill count; the depth is a power of two so pointers wrap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== rtl/prp_back.sv =====
module prp_back import prp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  prp_cfg_t   cfg,
	input  prp_qstat_t q_stat,
	input  prp_job_t   head,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_ready,
	output prp_out_t   res
);

	localparam int PM_W = QUO_W + 16;
	localparam int OX_W = ROT_W + PM_W + 1;
	localparam int OY_W = PIT_W + PM_W + 1;

	logic en;

	// Divider pipeline: one quotient bit per stage.
	logic              dv_v_s   [QUO_W];
	prp_job_t          dv_job_s [QUO_W];
	logic [DIV_W-1:0]  dv_rem_s [QUO_W];
	logic [QUO_W-1:0]  dv_quo_s [QUO_W];

	prp_job_t          src_job  [QUO_W];
	logic [DIV_W-1:0]  src_rem  [QUO_W];
	logic [QUO_W-1:0]  src_quo  [QUO_W];
	logic [REM_W-1:0]  trial    [QUO_W];
	logic              ge       [QUO_W];
	logic [DIV_W-1:0]  nxt_rem  [QUO_W];
	logic [QUO_W-1:0]  nxt_quo  [QUO_W];

	// Screen stages.
	logic sc_v_s1, sc_v_s2, sc_v_s3, res_v_q;
	prp_job_t job_s1, job_s2;
	logic [QUO_W-1:0] persp_s1, persp_s2;
	logic [PM_W-1:0] pm_s1;
	logic signed [OX_W-1:0] ox_s2;
	logic signed [OY_W-1:0] oy_s2;
	logic signed [OX_W-27:0] offx_s3;
	logic signed [OY_W-27:0] offy_s3;
	logic [15:0] depth_s3, pf_s3;
	logic clip_s3;
	prp_out_t res_q;

	logic signed [OX_W-1:0] ox_rnd;
	logic signed [OY_W-1:0] oy_rnd;
	logic [16:0] depth_sat, sx_sat, sy_sat;

	// The back part moves as one whenever the output register is free or taken.
	assign en        = !res_v_q || res_ready;
	assign pop       = en && !q_stat.empty;
	assign res_valid = res_v_q;
	assign res       = res_q;

	// One restoring step per stage; the dividend is 2^26 plus half the divisor.
	always_comb begin
		src_job[0] = head;
		src_rem[0] = DIV_W'(1 << (NUM_SHIFT - QUO_W));
		src_quo[0] = '0;
		for (int k = 1; k < QUO_W; k++) begin
			src_job[k] = dv_job_s[k-1];
			src_rem[k] = dv_rem_s[k-1];
			src_quo[k] = dv_quo_s[k-1];
		end
		for (int k = 0; k < QUO_W; k++) begin
			trial[k]   = {src_rem[k], src_job[k].div[QUO_W-k]};
			ge[k]      = trial[k] >= REM_W'(src_job[k].div);
			nxt_rem[k] = ge[k] ? DIV_W'(trial[k] - REM_W'(src_job[k].div))
			                   : DIV_W'(trial[k]);
			nxt_quo[k] = src_quo[k];
			nxt_quo[k][QUO_W-1-k] = ge[k];
		end
	end

	// Rounding of the screen offsets and saturation of the results.
	always_comb begin
		ox_rnd    = ox_s2 + OX_W'(RND26);
		oy_rnd    = oy_s2 + OY_W'(RND26);
		depth_sat = sat16(34'(job_s2.z2));
		sx_sat    = sat16(34'($signed({1'b0, cfg.centre_x})) + 34'(offx_s3));
		sy_sat    = sat16(34'($signed({1'b0, cfg.centre_y})) - 34'(offy_s3));
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QUO_W; k++) begin
				dv_v_s[k] <= 1'b0;
			end
			sc_v_s1 <= 1'b0;
			sc_v_s2 <= 1'b0;
			sc_v_s3 <= 1'b0;
			res_v_q <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= !q_stat.empty;
			for (int k = 1; k < QUO_W; k++) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
			sc_v_s1 <= dv_v_s[QUO_W-1];
			sc_v_s2 <= sc_v_s1;
			sc_v_s3 <= sc_v_s2;
			res_v_q <= sc_v_s3;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QUO_W; k++) begin
				dv_job_s[k] <= src_job[k];
				dv_rem_s[k] <= nxt_rem[k];
				dv_quo_s[k] <= nxt_quo[k];
			end

			job_s1   <= dv_job_s[QUO_W-1];
			persp_s1 <= dv_quo_s[QUO_W-1];
			pm_s1    <= dv_quo_s[QUO_W-1] * cfg.pixel_scale;

			job_s2   <= job_s1;
			persp_s2 <= persp_s1;
			ox_s2    <= job_s1.x1 * $signed({1'b0, pm_s1});
			oy_s2    <= job_s1.y2 * $signed({1'b0, pm_s1});

			offx_s3  <= ox_rnd[OX_W-1:26];
			offy_s3  <= oy_rnd[OY_W-1:26];
			depth_s3 <= depth_sat[15:0];
			pf_s3    <= (persp_s2 > QUO_W'(16'hFFFF)) ? 16'hFFFF : persp_s2[15:0];
			clip_s3  <= job_s2.clip;

			res_q.screen_x     <= sx_sat[15:0];
			res_q.screen_y     <= sy_sat[15:0];
			res_q.view_depth   <= depth_s3;
			res_q.persp_factor <= pf_s3;
			res_q.clipped      <= clip_s3 | sx_sat[16] | sy_sat[16];
		end
	end

endmodule

// ===== rtl/point_rotate_project_core.sv =====
// Rotates a stream of 3D points by yaw and pitch and projects them to screen
// coordinates. Points enter on the pt channel (valid/ready, one request per
// point) and results leave on the res channel (valid/ready) in the same order.
// Every point gives exactly one result.
// When nothing stalls, an accepted point passes six front stages (rotation
// and divisor), an entry of the queue, 19 stages of the perspective divider
// (one quotient bit each) and four screen stages ending in the output register.
// Throughput is one point per cycle while the receiver does not stall; the
// divider is fully pipelined.
// When the receiver stalls, the back part holds and the four-entry queue
// absorbs what the front still has in flight; pt_ready drops only when the
// queue is full and the last front stage holds a point.
// Reset clears all valid bits and the queue, and loads the registers with
// identity rotation, centre 0 and pixel scale 16. Registers are written over the APB
// port at byte address 4*index and should change only while the block is idle.
`include "assert_macros.svh"

module point_rotate_project_core import prp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_ready,
	input  prp_in_t            pt,
	output logic               res_valid,
	input  logic               res_ready,
	output prp_out_t           res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	prp_cfg_t cfg_q;
	logic [2:0] reg_idx;
	logic push, pop;
	prp_job_t wr_job, rd_job;
	prp_qstat_t q_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_yaw     <= 16'sd16384;
			cfg_q.sin_yaw     <= 16'sd0;
			cfg_q.cos_pitch   <= 16'sd16384;
			cfg_q.sin_pitch   <= 16'sd0;
			cfg_q.centre_x    <= 16'd0;
			cfg_q.centre_y    <= 16'd0;
			cfg_q.pixel_scale <= 16'd16;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_COS_YAW:     cfg_q.cos_yaw     <= pwdata[15:0];
				REG_SIN_YAW:     cfg_q.sin_yaw     <= pwdata[15:0];
				REG_COS_PITCH:   cfg_q.cos_pitch   <= pwdata[15:0];
				REG_SIN_PITCH:   cfg_q.sin_pitch   <= pwdata[15:0];
				REG_CENTRE_X:    cfg_q.centre_x    <= pwdata[15:0];
				REG_CENTRE_Y:    cfg_q.centre_y    <= pwdata[15:0];
				REG_PIXEL_SCALE: cfg_q.pixel_scale <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_COS_YAW:     prdata[15:0] = cfg_q.cos_yaw;
			REG_SIN_YAW:     prdata[15:0] = cfg_q.sin_yaw;
			REG_COS_PITCH:   prdata[15:0] = cfg_q.cos_pitch;
			REG_SIN_PITCH:   prdata[15:0] = cfg_q.sin_pitch;
			REG_CENTRE_X:    prdata[15:0] = cfg_q.centre_x;
			REG_CENTRE_Y:    prdata[15:0] = cfg_q.centre_y;
			REG_PIXEL_SCALE: prdata[15:0] = cfg_q.pixel_scale;
			default: ;
		endcase
	end

	prp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pt_valid (pt_valid),
		.pt_ready (pt_ready),
		.pt       (pt),
		.q_stat   (q_stat),
		.push     (push),
		.job      (wr_job)
	);

	prp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.q_stat (q_stat)
	);

	prp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.head      (rd_job),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Queue and front-end flow checks.
	`PRP_ASSERT_SAME(a_no_push_full, push, !q_stat.full, "queue written while full")
	`PRP_ASSERT_SAME(a_no_pop_empty, pop, !q_stat.empty, "queue read while empty")
	`PRP_ASSERT_SAME(a_ready_with_room, !q_stat.full, pt_ready, "front stalled with queue room")
	`PRP_ASSERT_NEXT(a_push_fills, push, !q_stat.empty, "queue empty after a write")

endmodule
